@@ hdl/udcm_pkg.sv @@
// Shared constants, types and helper functions of the update distance correlation monitor.
`default_nettype none

package udcm_pkg;

  // Table size default; the top level hands it down as a parameter
  localparam int TABLE_BLOCKS_DEF = 1048576;

  // Distance coding
  localparam int DISTANCE_CAP = 8192;
  localparam int DISTANCE_UNIT_BLOCKS = 4096;
  localparam int UNIT_SHIFT = $clog2(DISTANCE_UNIT_BLOCKS);
  localparam int DIST_W = $clog2(DISTANCE_CAP);
  localparam int CODE_W = $clog2(DISTANCE_CAP + 1);

  // Request limits and field widths
  localparam int MAX_REQUEST_BLOCKS = 256;
  localparam int OFFSET_W = 20;
  localparam int BCOUNT_W = 9;
  localparam int GIDX_W = 3;
  localparam int SUM_W = OFFSET_W + 1;

  // Sequence numbers and counters
  localparam int SEQ_W = 48;
  localparam int CNT_W = 48;

  // Threshold grid; histogram bins are {prev bucket, curr bucket}
  localparam int GRID_SIDE = 6;
  localparam int BASE_THRESHOLD = 16;
  localparam int BUCKET_W = 3;
  localparam int BIN_W = 2 * BUCKET_W;
  localparam int HIST_DEPTH = GRID_SIDE * (1 << BUCKET_W);

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One block table entry
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  // Histogram access kinds
  typedef enum logic [1:0] {
    HIST_INC  = 2'd0,
    HIST_SCAN = 2'd1,
    HIST_CLR  = 2'd2
  } hist_op_e;

  // Request from the control logic to the histogram unit
  typedef struct packed {
    logic             valid;
    hist_op_e         op;
    logic [BIN_W-1:0] bin;
  } hist_cmd_t;

  // Saturating increment of a 48-bit value
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == '1) ? v : v + CNT_W'(1);
    return r;
  endfunction

  // Saturating add of two 48-bit values
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // Smallest grid index whose threshold covers v, GRID_SIDE when none does
  function automatic logic [BUCKET_W-1:0] bucket(input logic [DIST_W-1:0] v);
    logic [BUCKET_W-1:0] b;
    b = BUCKET_W'(GRID_SIDE);
    for (int r = GRID_SIDE - 1; r >= 0; r--) begin
      if (int'(v) <= (BASE_THRESHOLD << r)) begin
        b = BUCKET_W'(r);
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/update_distance_correlation_monitor.sv @@
// Top level: request sequencer, per-block distance stage and grid readout.
// After reset the block runs a clearing pass over the block table, one entry per cycle,
// with busy high. A write request with N blocks (N capped at 256) steps through them
// one per cycle on the block table read port, then drains the distance and histogram
// stages; the result strobe comes once the last blocks have left those stages, and busy
// falls with it. A grid read walks the histogram memory one bin per cycle, 7 * (row + 1)
// bins, and returns once the last bin has been accumulated.
// Non-write requests, zero-length requests and reads outside the grid answer in the
// next cycle without raising busy. done_o marks each result for exactly one cycle; the
// receiver cannot stall it, so results must be captured in that cycle.
`default_nettype none

module update_distance_correlation_monitor #(
  parameter int TABLE_BLOCKS = udcm_pkg::TABLE_BLOCKS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            cmd_i,
  input  wire logic                            is_write_i,
  input  wire logic [udcm_pkg::OFFSET_W-1:0]   block_offset_i,
  input  wire logic [udcm_pkg::BCOUNT_W-1:0]   block_count_i,
  input  wire logic [udcm_pkg::GIDX_W-1:0]     prev_threshold_index_i,
  input  wire logic [udcm_pkg::GIDX_W-1:0]     curr_threshold_index_i,
  output logic                                 done_o,
  output logic [udcm_pkg::CNT_W-1:0]           denominator_count_o,
  output logic [udcm_pkg::CNT_W-1:0]           numerator_count_o,
  output logic                                 out_of_range_o
);

  localparam int AW = $clog2(TABLE_BLOCKS);
  localparam int EXT_W = (udcm_pkg::SUM_W > AW + 1) ? udcm_pkg::SUM_W : AW + 1;
  localparam logic [udcm_pkg::BUCKET_W-1:0] CbLast = udcm_pkg::BUCKET_W'(udcm_pkg::GRID_SIDE);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_SCAN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]                   sweep_q, sweep_d;
  logic [udcm_pkg::SEQ_W-1:0]      seq_q, seq_d;
  logic [udcm_pkg::OFFSET_W-1:0]   offset_q, offset_d;
  logic [udcm_pkg::BCOUNT_W-1:0]   cnt_q, cnt_d;
  logic [udcm_pkg::BCOUNT_W-1:0]   idx_q, idx_d;
  logic                            oor_flag_q, oor_flag_d;
  logic [udcm_pkg::GIDX_W-1:0]     row_q, row_d;
  logic [udcm_pkg::GIDX_W-1:0]     col_q, col_d;
  logic [udcm_pkg::BUCKET_W-1:0]   scan_pb_q, scan_pb_d;
  logic [udcm_pkg::BUCKET_W-1:0]   scan_cb_q, scan_cb_d;
  logic [udcm_pkg::BUCKET_W-1:0]   scan_tag_q;
  logic                            scan_issue_q, scan_issue_d;
  logic [udcm_pkg::CNT_W-1:0]      den_acc_q, den_acc_d;
  logic [udcm_pkg::CNT_W-1:0]      num_acc_q, num_acc_d;
  logic                            done_q, done_d;
  logic [udcm_pkg::CNT_W-1:0]      den_q, den_d;
  logic [udcm_pkg::CNT_W-1:0]      num_q, num_d;
  logic                            oor_q, oor_d;

  // Block pipeline
  logic                            p1_valid_q;
  logic [AW-1:0]                   p1_addr_q;
  logic [udcm_pkg::SEQ_W-1:0]      p1_seq_q;
  logic                            p2_valid_q, p2_valid_d;
  logic [udcm_pkg::DIST_W-1:0]     p2_prev_q, p2_prev_d;
  logic [udcm_pkg::DIST_W-1:0]     p2_curr_q, p2_curr_d;

  logic [EXT_W-1:0]                addr_ext;
  logic                            in_range;
  logic                            issue_rd;
  logic                            tbl_clr;
  udcm_pkg::tbl_entry_t            tbl_rd;
  udcm_pkg::tbl_entry_t            tbl_wr_data;
  udcm_pkg::tbl_entry_t            new_entry;
  logic                            tbl_wr_en;
  logic [AW-1:0]                   tbl_wr_addr;

  logic [udcm_pkg::SEQ_W-1:0]      diff;
  logic [udcm_pkg::SEQ_W-1:0]      diff_units;
  logic [udcm_pkg::DIST_W-1:0]     curr_dist;
  logic [udcm_pkg::CODE_W-1:0]     prev_full;
  logic                            has_last;
  logic                            has_code;
  logic [udcm_pkg::BUCKET_W-1:0]   p2_pb;
  logic [udcm_pkg::BUCKET_W-1:0]   p2_cb;

  udcm_pkg::hist_cmd_t             hist_cmd;
  logic                            hist_busy;
  logic                            scan_valid;
  logic [udcm_pkg::CNT_W-1:0]      scan_data;
  logic [udcm_pkg::BCOUNT_W-1:0]   cnt_sat;

  // Block address of the current step
  assign addr_ext = EXT_W'(offset_q) + EXT_W'(idx_q);
  assign in_range = addr_ext < EXT_W'(TABLE_BLOCKS);

  assign cnt_sat = (block_count_i > udcm_pkg::BCOUNT_W'(udcm_pkg::MAX_REQUEST_BLOCKS)) ?
                   udcm_pkg::BCOUNT_W'(udcm_pkg::MAX_REQUEST_BLOCKS) : block_count_i;

  // Stage 1: update distance from the stored sequence number
  assign diff       = p1_seq_q - tbl_rd.seq;
  assign diff_units = diff >> udcm_pkg::UNIT_SHIFT;
  assign curr_dist  = (diff_units > udcm_pkg::SEQ_W'(udcm_pkg::DISTANCE_CAP - 1)) ?
                      udcm_pkg::DIST_W'(udcm_pkg::DISTANCE_CAP - 1) :
                      diff_units[udcm_pkg::DIST_W-1:0];
  assign has_last   = tbl_rd.seq != '0;
  assign has_code   = tbl_rd.code != '0;
  assign prev_full  = tbl_rd.code - udcm_pkg::CODE_W'(1);

  assign new_entry.seq  = p1_seq_q;
  assign new_entry.code = has_last ?
                          udcm_pkg::CODE_W'(curr_dist) + udcm_pkg::CODE_W'(1) : tbl_rd.code;

  assign p2_valid_d = p1_valid_q && has_last && has_code;
  assign p2_prev_d  = prev_full[udcm_pkg::DIST_W-1:0];
  assign p2_curr_d  = curr_dist;

  // Table write port: clearing pass or stage 1 write-back
  assign tbl_wr_en   = tbl_clr || p1_valid_q;
  assign tbl_wr_addr = tbl_clr ? sweep_q : p1_addr_q;
  assign tbl_wr_data = tbl_clr ? '0 : new_entry;

  // Stage 2: histogram bin of the distance pair
  assign p2_pb = udcm_pkg::bucket(p2_prev_q);
  assign p2_cb = udcm_pkg::bucket(p2_curr_q);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    seq_d        = seq_q;
    offset_d     = offset_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    oor_flag_d   = oor_flag_q;
    row_d        = row_q;
    col_d        = col_q;
    scan_pb_d    = scan_pb_q;
    scan_cb_d    = scan_cb_q;
    scan_issue_d = scan_issue_q;
    den_acc_d    = den_acc_q;
    num_acc_d    = num_acc_q;
    done_d       = 1'b0;
    den_d        = den_q;
    num_d        = num_q;
    oor_d        = oor_q;
    hist_cmd     = '0;
    tbl_clr      = 1'b0;
    issue_rd     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        tbl_clr = 1'b1;
        if (sweep_q < AW'(udcm_pkg::HIST_DEPTH)) begin
          hist_cmd.valid = 1'b1;
          hist_cmd.op    = udcm_pkg::HIST_CLR;
          hist_cmd.bin   = sweep_q[udcm_pkg::BIN_W-1:0];
        end
        if (sweep_q == AW'(TABLE_BLOCKS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (cmd_i) begin
            if (prev_threshold_index_i < udcm_pkg::GIDX_W'(udcm_pkg::GRID_SIDE) &&
                curr_threshold_index_i < udcm_pkg::GIDX_W'(udcm_pkg::GRID_SIDE)) begin
              row_d        = prev_threshold_index_i;
              col_d        = curr_threshold_index_i;
              scan_pb_d    = '0;
              scan_cb_d    = '0;
              scan_issue_d = 1'b1;
              den_acc_d    = '0;
              num_acc_d    = '0;
              state_d      = ST_SCAN;
            end else begin
              done_d = 1'b1;
              den_d  = '0;
              num_d  = '0;
              oor_d  = 1'b0;
            end
          end else if (is_write_i && block_count_i != '0) begin
            offset_d   = block_offset_i;
            cnt_d      = cnt_sat;
            idx_d      = '0;
            oor_flag_d = 1'b0;
            state_d    = ST_ISSUE;
          end else begin
            done_d = 1'b1;
            den_d  = '0;
            num_d  = '0;
            oor_d  = 1'b0;
          end
        end
      end

      ST_ISSUE: begin
        if (in_range) begin
          issue_rd = 1'b1;
          seq_d    = udcm_pkg::sat_inc(seq_q);
        end else begin
          oor_flag_d = 1'b1;
        end
        idx_d = idx_q + udcm_pkg::BCOUNT_W'(1);
        if (idx_q == cnt_q - udcm_pkg::BCOUNT_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        if (!p1_valid_q && !p2_valid_q && !hist_busy) begin
          done_d  = 1'b1;
          den_d   = '0;
          num_d   = '0;
          oor_d   = oor_flag_q;
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // Issue one bin per cycle: rows 0..row, all current buckets
        if (scan_issue_q) begin
          hist_cmd.valid = 1'b1;
          hist_cmd.op    = udcm_pkg::HIST_SCAN;
          hist_cmd.bin   = {scan_pb_q, scan_cb_q};
          if (scan_pb_q == row_q && scan_cb_q == CbLast) begin
            scan_issue_d = 1'b0;
          end else if (scan_cb_q == CbLast) begin
            scan_cb_d = '0;
            scan_pb_d = scan_pb_q + udcm_pkg::BUCKET_W'(1);
          end else begin
            scan_cb_d = scan_cb_q + udcm_pkg::BUCKET_W'(1);
          end
        end
        // Accumulate bin data; numerator only for buckets inside the column
        if (scan_valid) begin
          den_acc_d = udcm_pkg::sat_add(den_acc_q, scan_data);
          if (scan_tag_q <= udcm_pkg::BUCKET_W'(col_q)) begin
            num_acc_d = udcm_pkg::sat_add(num_acc_q, scan_data);
          end
          if (!scan_issue_q) begin
            done_d  = 1'b1;
            den_d   = den_acc_d;
            num_d   = num_acc_d;
            oor_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    if (p2_valid_q && p2_pb < udcm_pkg::BUCKET_W'(udcm_pkg::GRID_SIDE)) begin
      hist_cmd.valid = 1'b1;
      hist_cmd.op    = udcm_pkg::HIST_INC;
      hist_cmd.bin   = {p2_pb, p2_cb};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      sweep_q      <= '0;
      seq_q        <= udcm_pkg::SEQ_W'(1);
      idx_q        <= '0;
      cnt_q        <= '0;
      oor_flag_q   <= 1'b0;
      scan_issue_q <= 1'b0;
      done_q       <= 1'b0;
      p1_valid_q   <= 1'b0;
      p2_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      seq_q        <= seq_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      oor_flag_q   <= oor_flag_d;
      scan_issue_q <= scan_issue_d;
      done_q       <= done_d;
      p1_valid_q   <= issue_rd;
      p2_valid_q   <= p2_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    offset_q   <= offset_d;
    row_q      <= row_d;
    col_q      <= col_d;
    scan_pb_q  <= scan_pb_d;
    scan_cb_q  <= scan_cb_d;
    scan_tag_q <= scan_cb_q;
    den_acc_q  <= den_acc_d;
    num_acc_q  <= num_acc_d;
    den_q      <= den_d;
    num_q      <= num_d;
    oor_q      <= oor_d;
    p1_addr_q  <= addr_ext[AW-1:0];
    p1_seq_q   <= seq_q;
    p2_prev_q  <= p2_prev_d;
    p2_curr_q  <= p2_curr_d;
  end

  udcm_block_table #(
    .TABLE_BLOCKS (TABLE_BLOCKS),
    .AW           (AW)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (issue_rd),
    .rd_addr_i (addr_ext[AW-1:0]),
    .rd_data_o (tbl_rd),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (tbl_wr_data)
  );

  udcm_hist u_hist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (hist_cmd),
    .busy_o       (hist_busy),
    .scan_valid_o (scan_valid),
    .scan_data_o  (scan_data)
  );

  assign busy                = (state_q != ST_IDLE);
  assign done_o              = done_q;
  assign denominator_count_o = den_q;
  assign numerator_count_o   = num_q;
  assign out_of_range_o      = oor_q;

  // Idle means nothing is left in flight
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (!p1_valid_q && !p2_valid_q && !hist_busy))
    else $error("idle with a block transaction still in flight");

  // The stored sequence of a block is never newer than the one being assigned
  a_seq_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q |-> (p1_seq_q >= tbl_rd.seq))
    else $error("block table holds a newer sequence than the current write");

  // Counts and the range flag never appear in the same result
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (denominator_count_o == '0 && numerator_count_o == '0))
    else $error("range flag on a read result");

endmodule

`default_nettype wire

@@ hdl/udcm_block_table.sv @@
// Per-block table memory: last write sequence and coded previous distance.
`default_nettype none

module udcm_block_table #(
  parameter int TABLE_BLOCKS = udcm_pkg::TABLE_BLOCKS_DEF,
  parameter int AW = $clog2(TABLE_BLOCKS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rd_en_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output udcm_pkg::tbl_entry_t       rd_data_o,
  input  wire logic                  wr_en_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire udcm_pkg::tbl_entry_t  wr_data_i
);

  udcm_pkg::tbl_entry_t mem_q [TABLE_BLOCKS];
  udcm_pkg::tbl_entry_t rd_q;

  // Simple dual port with a registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

@@ hdl/udcm_hist.sv @@
// Distance-pair histogram: saturating read-modify-write with forwarding, scan read, clear.
`default_nettype none

module udcm_hist (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire udcm_pkg::hist_cmd_t          cmd_i,
  output logic                              busy_o,
  output logic                              scan_valid_o,
  output logic [udcm_pkg::CNT_W-1:0]        scan_data_o
);

  logic [udcm_pkg::CNT_W-1:0] mem_q [udcm_pkg::HIST_DEPTH];
  logic [udcm_pkg::CNT_W-1:0] rd_q;

  logic                         s_valid_q;
  udcm_pkg::hist_op_e           s_op_q;
  logic [udcm_pkg::BIN_W-1:0]   s_bin_q;

  logic                         fwd_valid_q;
  logic [udcm_pkg::BIN_W-1:0]   fwd_bin_q;
  logic [udcm_pkg::CNT_W-1:0]   fwd_data_q;

  logic                         rd_en;
  logic                         clr_wr;
  logic                         inc_wr;
  logic                         fwd_hit;
  logic [udcm_pkg::CNT_W-1:0]   cur_val;
  logic [udcm_pkg::CNT_W-1:0]   inc_val;

  // Access decode
  assign rd_en  = cmd_i.valid &&
                  (cmd_i.op == udcm_pkg::HIST_INC || cmd_i.op == udcm_pkg::HIST_SCAN);
  assign clr_wr = cmd_i.valid && (cmd_i.op == udcm_pkg::HIST_CLR);

  // Second stage: bypass the write of the previous cycle to the same bin
  assign fwd_hit = fwd_valid_q && (fwd_bin_q == s_bin_q);
  assign cur_val = fwd_hit ? fwd_data_q : rd_q;
  assign inc_val = udcm_pkg::sat_inc(cur_val);
  assign inc_wr  = s_valid_q && (s_op_q == udcm_pkg::HIST_INC);

  // Memory array
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[cmd_i.bin];
    end
    if (inc_wr) begin
      mem_q[s_bin_q] <= inc_val;
    end else if (clr_wr) begin
      mem_q[cmd_i.bin] <= '0;
    end
  end

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      s_op_q      <= udcm_pkg::HIST_INC;
      fwd_valid_q <= 1'b0;
    end else begin
      s_valid_q   <= rd_en;
      s_op_q      <= cmd_i.op;
      fwd_valid_q <= inc_wr;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    s_bin_q    <= cmd_i.bin;
    fwd_bin_q  <= s_bin_q;
    fwd_data_q <= inc_val;
  end

  assign busy_o       = s_valid_q;
  assign scan_valid_o = s_valid_q && (s_op_q == udcm_pkg::HIST_SCAN);
  assign scan_data_o  = cur_val;

  // A scan result always follows a scan request in the next cycle
  a_scan_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_valid_o |-> $past(cmd_i.valid && cmd_i.op == udcm_pkg::HIST_SCAN))
    else $error("scan data without a scan request");

  // An increment never wraps a bin back to zero
  a_inc_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inc_wr |-> (inc_val != '0))
    else $error("histogram bin wrapped");

endmodule

`default_nettype wire
